/* sv/wsv_pkg.sv */
// Shared types and constants of the wraparound scrolling viewport.
// No dependencies; used by the interfaces, the tick and split units and the top level.
package wsv_pkg;

  // Fixed field widths.
  localparam int unsigned ORIGIN_W = 13;
  localparam int unsigned SPEED_W  = 10;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned PIECE_W  = 2;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // Reset image size.
  localparam int unsigned WIDTH_RST  = 640;
  localparam int unsigned HEIGHT_RST = 480;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_SCROLL_SPEED = 2'd2,
    REG_SCROLL_DIR   = 2'd3
  } reg_e;

endpackage

/* sv/wsv_if.sv */
// Valid/ready channel interfaces for viewport commands and rectangle pieces.
// Depends on wsv_pkg for the fixed origin width.
interface wsv_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    cmd;
  logic signed [wsv_pkg::ORIGIN_W-1:0]     dest_origin_x;
  logic signed [wsv_pkg::ORIGIN_W-1:0]     dest_origin_y;

  modport source (output valid, cmd, dest_origin_x, dest_origin_y, input ready);
  modport sink (input valid, cmd, dest_origin_x, dest_origin_y, output ready);
endinterface

interface wsv_out_if #(
  parameter int unsigned DIM_BITS = 12
);
  localparam int unsigned ViewW = DIM_BITS + 2;
  localparam int unsigned DestW = DIM_BITS + 3;

  logic                    valid;
  logic                    ready;
  logic signed [DestW-1:0] out_dest_x;
  logic signed [DestW-1:0] out_dest_y;
  logic signed [ViewW-1:0] src_x;
  logic signed [ViewW-1:0] src_y;
  logic signed [ViewW-1:0] piece_width;
  logic signed [ViewW-1:0] piece_height;
  logic                    last_piece;

  modport source (output valid, out_dest_x, out_dest_y, src_x, src_y, piece_width,
                  piece_height, last_piece, input ready);
  modport sink (input valid, out_dest_x, out_dest_y, src_x, src_y, piece_width,
                piece_height, last_piece, output ready);
endinterface

/* sv/wrapping_scroll_viewport_splitter.sv */
// Wraparound scrolling viewport: a tick beat retires in the cycle after it is accepted. A
// draw beat holds the work stage for its one, two or four pieces and loads them into the
// single output register one piece per cycle while that register is free or being drained;
// a tick never waits on the output, so ticks flow back to back. Reset clears the viewport
// to the reset image size, the registers to their reset values and both stages to empty.
// Depends on wsv_pkg, wsv_if, wsv_tick and wsv_split.
module wrapping_scroll_viewport_splitter #(
  parameter int unsigned DIM_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wsv_in_if.sink                        in_i,
  wsv_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wsv_pkg::ADDR_W-1:0]    paddr,
  input  logic [wsv_pkg::DATA_W-1:0]    pwdata,
  output logic [wsv_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned ViewW = DIM_BITS + 2;
  localparam int unsigned DestW = DIM_BITS + 3;

  // Configuration registers.
  logic [DIM_BITS-1:0]          width_q, height_q;
  logic [wsv_pkg::SPEED_W-1:0]  speed_q;
  wsv_pkg::dir_e                dir_q;
  wsv_pkg::reg_e                reg_sel;
  logic                         cfg_wr;

  // Viewport state.
  logic signed [ViewW-1:0] left_q, top_q, right_q, bottom_q;
  logic signed [ViewW-1:0] left_d, top_d, right_d, bottom_d;

  // Work stage: the accepted command waits here while its pieces go out.
  logic                                  work_valid_q;
  wsv_pkg::cmd_e                         work_cmd_q;
  logic signed [wsv_pkg::ORIGIN_W-1:0]   work_x_q, work_y_q;
  logic [wsv_pkg::PIECE_W-1:0]           piece_q, piece_d;

  // Piece currently selected by the split unit.
  logic signed [DestW-1:0] pc_dest_x, pc_dest_y;
  logic signed [ViewW-1:0] pc_src_x, pc_src_y, pc_w, pc_h;
  logic                    pc_last;

  // Output register.
  logic                    out_valid_q;
  logic signed [DestW-1:0] out_dest_x_q, out_dest_y_q;
  logic signed [ViewW-1:0] out_src_x_q, out_src_y_q, out_w_q, out_h_q;
  logic                    out_last_q;

  logic out_load, retire, is_tick, in_take;

  // ---------------------------------------------------------------------------------------
  // APB configuration. pready is tied high, so a write lands at the access cycle.
  // ---------------------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = wsv_pkg::reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_sel)
      wsv_pkg::REG_IMAGE_WIDTH:  prdata = wsv_pkg::DATA_W'(width_q);
      wsv_pkg::REG_IMAGE_HEIGHT: prdata = wsv_pkg::DATA_W'(height_q);
      wsv_pkg::REG_SCROLL_SPEED: prdata = wsv_pkg::DATA_W'(speed_q);
      wsv_pkg::REG_SCROLL_DIR:   prdata = wsv_pkg::DATA_W'(dir_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_BITS'(wsv_pkg::WIDTH_RST);
      height_q <= DIM_BITS'(wsv_pkg::HEIGHT_RST);
      speed_q  <= '0;
      dir_q    <= wsv_pkg::DIR_UP;
    end else if (cfg_wr) begin
      case (reg_sel)
        wsv_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[DIM_BITS-1:0];
        wsv_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[DIM_BITS-1:0];
        wsv_pkg::REG_SCROLL_SPEED: speed_q  <= pwdata[wsv_pkg::SPEED_W-1:0];
        wsv_pkg::REG_SCROLL_DIR:   dir_q    <= wsv_pkg::dir_e'(pwdata[wsv_pkg::DIR_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Work stage control. A tick retires without waiting on the output. A draw loads one
  // piece per cycle into the output register whenever that register is free or being
  // drained, and retires with its last piece. A new beat enters as the old one retires.
  // ---------------------------------------------------------------------------------------
  assign is_tick  = work_cmd_q == wsv_pkg::CMD_TICK;
  assign out_load = work_valid_q && !is_tick && (!out_valid_q || out_o.ready);
  assign retire   = work_valid_q && (is_tick || (out_load && pc_last));
  assign in_i.ready = !work_valid_q || retire;
  assign in_take  = in_i.valid && in_i.ready;

  always_comb begin
    piece_d = piece_q;
    if (retire) begin
      piece_d = '0;
    end else if (out_load) begin
      piece_d = piece_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      piece_q      <= '0;
    end else begin
      piece_q <= piece_d;
      if (in_take) begin
        work_valid_q <= 1'b1;
      end else if (retire) begin
        work_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      work_cmd_q <= wsv_pkg::cmd_e'(in_i.cmd);
      work_x_q   <= in_i.dest_origin_x;
      work_y_q   <= in_i.dest_origin_y;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Viewport update. The stored rectangle moves only when a tick retires, so a draw that
  // follows sees every earlier tick.
  // ---------------------------------------------------------------------------------------
  wsv_tick #(
    .DIM_BITS (DIM_BITS)
  ) u_tick (
    .left_i   (left_q),
    .top_i    (top_q),
    .right_i  (right_q),
    .bottom_i (bottom_q),
    .width_i  (width_q),
    .height_i (height_q),
    .speed_i  (speed_q),
    .dir_i    (dir_q),
    .left_o   (left_d),
    .top_o    (top_d),
    .right_o  (right_d),
    .bottom_o (bottom_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= ViewW'(wsv_pkg::WIDTH_RST);
      bottom_q <= ViewW'(wsv_pkg::HEIGHT_RST);
    end else if (work_valid_q && is_tick) begin
      left_q   <= left_d;
      top_q    <= top_d;
      right_q  <= right_d;
      bottom_q <= bottom_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Piece selection and the output register.
  // ---------------------------------------------------------------------------------------
  wsv_split #(
    .DIM_BITS (DIM_BITS)
  ) u_split (
    .left_i   (left_q),
    .top_i    (top_q),
    .right_i  (right_q),
    .bottom_i (bottom_q),
    .width_i  (width_q),
    .height_i (height_q),
    .x_i      (work_x_q),
    .y_i      (work_y_q),
    .piece_i  (piece_q),
    .dest_x_o (pc_dest_x),
    .dest_y_o (pc_dest_y),
    .src_x_o  (pc_src_x),
    .src_y_o  (pc_src_y),
    .size_w_o (pc_w),
    .size_h_o (pc_h),
    .last_o   (pc_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_dest_x_q <= pc_dest_x;
      out_dest_y_q <= pc_dest_y;
      out_src_x_q  <= pc_src_x;
      out_src_y_q  <= pc_src_y;
      out_w_q      <= pc_w;
      out_h_q      <= pc_h;
      out_last_q   <= pc_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_dest_x   = out_dest_x_q;
  assign out_o.out_dest_y   = out_dest_y_q;
  assign out_o.src_x        = out_src_x_q;
  assign out_o.src_y        = out_src_y_q;
  assign out_o.piece_width  = out_w_q;
  assign out_o.piece_height = out_h_q;
  assign out_o.last_piece   = out_last_q;

endmodule

/* sv/wsv_tick.sv */
// Next viewport position for one scroll tick, with wraparound.
// Depends on wsv_pkg for the speed width and the direction codes.
module wsv_tick #(
  parameter int unsigned DIM_BITS = 12
) (
  input  logic signed [DIM_BITS+1:0]       left_i,
  input  logic signed [DIM_BITS+1:0]       top_i,
  input  logic signed [DIM_BITS+1:0]       right_i,
  input  logic signed [DIM_BITS+1:0]       bottom_i,
  input  logic        [DIM_BITS-1:0]       width_i,
  input  logic        [DIM_BITS-1:0]       height_i,
  input  logic        [wsv_pkg::SPEED_W-1:0] speed_i,
  input  wsv_pkg::dir_e                    dir_i,
  output logic signed [DIM_BITS+1:0]       left_o,
  output logic signed [DIM_BITS+1:0]       top_o,
  output logic signed [DIM_BITS+1:0]       right_o,
  output logic signed [DIM_BITS+1:0]       bottom_o
);

  localparam int unsigned ViewW = DIM_BITS + 2;
  localparam int unsigned CalcW = ViewW + 3;

  logic signed [CalcW-1:0] l, t, r, b, w, h, s;
  logic signed [CalcW-1:0] l_n, t_n, r_n, b_n;

  always_comb begin
    l = CalcW'(left_i);
    t = CalcW'(top_i);
    r = CalcW'(right_i);
    b = CalcW'(bottom_i);
    w = CalcW'(width_i);
    h = CalcW'(height_i);
    s = CalcW'(speed_i);
    l_n = l;
    t_n = t;
    r_n = r;
    b_n = b;
    case (dir_i)
      wsv_pkg::DIR_UP: begin
        t_n = t + s;
        b_n = b + s;
        if (t_n > h) begin
          b_n = b_n - t_n;
          t_n = '0;
        end
      end
      wsv_pkg::DIR_RIGHT: begin
        l_n = l - s;
        r_n = r - s;
        if (r_n < 0) begin
          l_n = w - (r_n - l_n);
          r_n = w;
        end
      end
      wsv_pkg::DIR_DOWN: begin
        t_n = t - s;
        b_n = b - s;
        if (b_n < 0) begin
          t_n = h - (b_n - t_n);
          b_n = h;
        end
      end
      default: begin
        l_n = l + s;
        r_n = r + s;
        if (l_n > w) begin
          r_n = r_n - l_n;
          l_n = '0;
        end
      end
    endcase
  end

  // The stored coordinates wrap to the ViewW-bit coordinate width.
  assign left_o   = l_n[ViewW-1:0];
  assign top_o    = t_n[ViewW-1:0];
  assign right_o  = r_n[ViewW-1:0];
  assign bottom_o = b_n[ViewW-1:0];

endmodule

/* sv/wsv_split.sv */
// Splits the viewport into source rectangles and returns the selected piece.
// Depends on wsv_pkg for the origin and piece index widths.
module wsv_split #(
  parameter int unsigned DIM_BITS = 12
) (
  input  logic signed [DIM_BITS+1:0]          left_i,
  input  logic signed [DIM_BITS+1:0]          top_i,
  input  logic signed [DIM_BITS+1:0]          right_i,
  input  logic signed [DIM_BITS+1:0]          bottom_i,
  input  logic        [DIM_BITS-1:0]          width_i,
  input  logic        [DIM_BITS-1:0]          height_i,
  input  logic signed [wsv_pkg::ORIGIN_W-1:0] x_i,
  input  logic signed [wsv_pkg::ORIGIN_W-1:0] y_i,
  input  logic        [wsv_pkg::PIECE_W-1:0]  piece_i,
  output logic signed [DIM_BITS+2:0]          dest_x_o,
  output logic signed [DIM_BITS+2:0]          dest_y_o,
  output logic signed [DIM_BITS+1:0]          src_x_o,
  output logic signed [DIM_BITS+1:0]          src_y_o,
  output logic signed [DIM_BITS+1:0]          size_w_o,
  output logic signed [DIM_BITS+1:0]          size_h_o,
  output logic                                last_o
);

  localparam int unsigned ViewW = DIM_BITS + 2;
  localparam int unsigned DestW = DIM_BITS + 3;
  localparam int unsigned CalcW = ((ViewW > wsv_pkg::ORIGIN_W) ? ViewW : wsv_pkg::ORIGIN_W) + 3;

  typedef enum logic [2:0] {
    SPLIT_QUAD,
    SPLIT_TOP,
    SPLIT_RIGHT,
    SPLIT_BOTTOM,
    SPLIT_LEFT,
    SPLIT_ONE
  } split_e;

  logic signed [CalcW-1:0] l, t, r, b, w, h, x, y;
  logic signed [CalcW-1:0] sx0, w0, w1, sy0, h0, h1;
  logic signed [CalcW-1:0] dx, dy, sx, sy, pw, ph;
  logic                    tn, ln, rp, bp;
  split_e                  kind;

  always_comb begin
    l = CalcW'(left_i);
    t = CalcW'(top_i);
    r = CalcW'(right_i);
    b = CalcW'(bottom_i);
    w = CalcW'(width_i);
    h = CalcW'(height_i);
    x = CalcW'(x_i);
    y = CalcW'(y_i);
    tn = t < 0;
    ln = l < 0;
    rp = r > w;
    bp = b > h;

    // Priority: both axes cross, then top, right, bottom, left, else whole.
    if ((tn || bp) && (ln || rp)) begin
      kind = SPLIT_QUAD;
    end else if (tn) begin
      kind = SPLIT_TOP;
    end else if (rp) begin
      kind = SPLIT_RIGHT;
    end else if (bp) begin
      kind = SPLIT_BOTTOM;
    end else if (ln) begin
      kind = SPLIT_LEFT;
    end else begin
      kind = SPLIT_ONE;
    end

    sx0 = ln ? w + l : l;
    w0  = ln ? -l : w - l;
    w1  = ln ? r : r - w;
    sy0 = tn ? h + t : t;
    h0  = tn ? -t : h - t;
    h1  = tn ? b : b - h;

    dx = x;
    dy = y;
    sx = l;
    sy = t;
    pw = r - l;
    ph = b - t;
    last_o = 1'b1;
    case (kind)
      SPLIT_QUAD: begin
        // Bit 0 of the piece index picks the column, bit 1 the row.
        dx = piece_i[0] ? x + w0 : x;
        dy = piece_i[1] ? y + h0 : y;
        sx = piece_i[0] ? '0 : sx0;
        sy = piece_i[1] ? '0 : sy0;
        pw = piece_i[0] ? w1 : w0;
        ph = piece_i[1] ? h1 : h0;
        last_o = &piece_i;
      end
      SPLIT_TOP: begin
        dy = piece_i[0] ? y - t : y;
        sy = piece_i[0] ? '0 : h + t;
        ph = piece_i[0] ? b : -t;
        last_o = piece_i[0];
      end
      SPLIT_RIGHT: begin
        dx = piece_i[0] ? x + (w - l) : x;
        sx = piece_i[0] ? '0 : l;
        pw = piece_i[0] ? r - w : w - l;
        last_o = piece_i[0];
      end
      SPLIT_BOTTOM: begin
        dy = piece_i[0] ? y + (h - t) : y;
        sy = piece_i[0] ? '0 : t;
        ph = piece_i[0] ? b - h : h - t;
        last_o = piece_i[0];
      end
      SPLIT_LEFT: begin
        dx = piece_i[0] ? x - l : x;
        sx = piece_i[0] ? '0 : w + l;
        pw = piece_i[0] ? r : -l;
        last_o = piece_i[0];
      end
      default: begin
        last_o = 1'b1;
      end
    endcase
  end

  assign dest_x_o = dx[DestW-1:0];
  assign dest_y_o = dy[DestW-1:0];
  assign src_x_o  = sx[ViewW-1:0];
  assign src_y_o  = sy[ViewW-1:0];
  assign size_w_o = pw[ViewW-1:0];
  assign size_h_o = ph[ViewW-1:0];

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the wraparound scrolling viewport: directed rows, then random phases.
// Depends on wsv_pkg, the wsv_in_if / wsv_out_if channels and the top level under test.
module tb;
  import wsv_pkg::*;

  typedef struct {
    logic signed [14:0] dx;
    logic signed [14:0] dy;
    logic signed [13:0] sx;
    logic signed [13:0] sy;
    logic signed [13:0] w;
    logic signed [13:0] h;
    logic               last;
  } piece_t;

  typedef enum logic {
    ROW_CFG,
    ROW_BEAT
  } row_kind_e;

  // One line of stimulus: either a register write or a command beat. A beat may carry a
  // hand-typed piece that replaces the predicted one.
  typedef struct {
    row_kind_e          kind;
    reg_e               cfg_reg;
    int                 cfg_val;
    cmd_e               cmd;
    logic signed [12:0] ox;
    logic signed [12:0] oy;
    bit                 pinned;
    piece_t             pin;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  wsv_in_if                   in_if ();
  wsv_out_if #(.DIM_BITS(12)) out_if ();

  wrapping_scroll_viewport_splitter #(
    .DIM_BITS(12)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow copy of the registers and the viewport.
  int                 img_w;
  int                 img_h;
  int                 speed;
  dir_e               heading;
  logic signed [13:0] view_l;
  logic signed [13:0] view_t;
  logic signed [13:0] view_r;
  logic signed [13:0] view_b;

  piece_t want_pieces[$];
  row_t   beat_pins[$];
  row_t   plan[$];

  int errors;
  int tick_count;
  int wrap_count;
  int draw_count;
  int split_count[5];
  int checked;
  int settings;
  bit steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic piece_t make_piece(int dx, int dy, int sx, int sy, int w, int h);
    piece_t p;
    p.dx   = 15'(dx);
    p.dy   = 15'(dy);
    p.sx   = 14'(sx);
    p.sy   = 14'(sy);
    p.w    = 14'(w);
    p.h    = 14'(h);
    p.last = 1'b0;
    return p;
  endfunction

  // Move the viewport one step and wrap it back into the image when it leaves.
  function automatic void scroll_view();
    int l, t, r, b;
    l = view_l;
    t = view_t;
    r = view_r;
    b = view_b;
    case (heading)
      DIR_UP: begin
        t += speed;
        b += speed;
        if (t > img_h) begin
          b = b - t;
          t = 0;
          wrap_count++;
        end
      end
      DIR_RIGHT: begin
        l -= speed;
        r -= speed;
        if (r < 0) begin
          l = img_w - (r - l);
          r = img_w;
          wrap_count++;
        end
      end
      DIR_DOWN: begin
        t -= speed;
        b -= speed;
        if (b < 0) begin
          t = img_h - (b - t);
          b = img_h;
          wrap_count++;
        end
      end
      default: begin
        l += speed;
        r += speed;
        if (l > img_w) begin
          r = r - l;
          l = 0;
          wrap_count++;
        end
      end
    endcase
    view_l = 14'(l);
    view_t = 14'(t);
    view_r = 14'(r);
    view_b = 14'(b);
    tick_count++;
  endfunction

  // Cut the viewport into the source rectangles that tile it, corners first, then the
  // single edge crossings, else one piece.
  function automatic void split_view(int x, int y);
    int     wd, ht, l, t, r, b, sx0, sy0, w0, w1, h0, h1, n;
    bit     tn, ln, rp, bp;
    piece_t pc[4];
    wd = img_w;
    ht = img_h;
    l  = view_l;
    t  = view_t;
    r  = view_r;
    b  = view_b;
    tn = t < 0;
    ln = l < 0;
    rp = r > wd;
    bp = b > ht;
    if ((tn || bp) && (ln || rp)) begin
      sx0   = ln ? wd + l : l;
      w0    = ln ? -l : wd - l;
      w1    = ln ? r : r - wd;
      sy0   = tn ? ht + t : t;
      h0    = tn ? -t : ht - t;
      h1    = tn ? b : b - ht;
      pc[0] = make_piece(x, y, sx0, sy0, w0, h0);
      pc[1] = make_piece(x + w0, y, 0, sy0, w1, h0);
      pc[2] = make_piece(x, y + h0, sx0, 0, w0, h1);
      pc[3] = make_piece(x + w0, y + h0, 0, 0, w1, h1);
      n     = 4;
    end else if (tn) begin
      pc[0] = make_piece(x, y, l, ht + t, r - l, -t);
      pc[1] = make_piece(x, y - t, l, 0, r - l, b);
      n     = 2;
    end else if (rp) begin
      pc[0] = make_piece(x, y, l, t, wd - l, b - t);
      pc[1] = make_piece(x + (wd - l), y, 0, t, r - wd, b - t);
      n     = 2;
    end else if (bp) begin
      pc[0] = make_piece(x, y, l, t, r - l, ht - t);
      pc[1] = make_piece(x, y + (ht - t), l, 0, r - l, b - ht);
      n     = 2;
    end else if (ln) begin
      pc[0] = make_piece(x, y, wd + l, t, -l, b - t);
      pc[1] = make_piece(x - l, y, 0, t, r, b - t);
      n     = 2;
    end else begin
      pc[0] = make_piece(x, y, l, t, r - l, b - t);
      n     = 1;
    end
    pc[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) want_pieces.push_back(pc[k]);
    draw_count++;
    split_count[n]++;
  endfunction

  function automatic void check_field(string name, logic signed [15:0] want,
                                      logic signed [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: piece %0d %s expected %0d got %0d", $time, checked, name, want, got);
    end
  endfunction

  // Pieces are checked against the oldest expectation; accepted commands feed the shadow.
  always @(posedge clk) begin : watch
    row_t   note;
    piece_t exp_piece;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (want_pieces.size() == 0) begin
          errors++;
          $display("%0t: unexpected piece dest (%0d,%0d) src (%0d,%0d) size %0dx%0d", $time,
                   out_if.out_dest_x, out_if.out_dest_y, out_if.src_x, out_if.src_y,
                   out_if.piece_width, out_if.piece_height);
        end else begin
          exp_piece = want_pieces.pop_front();
          check_field("out_dest_x", exp_piece.dx, out_if.out_dest_x);
          check_field("out_dest_y", exp_piece.dy, out_if.out_dest_y);
          check_field("src_x", exp_piece.sx, out_if.src_x);
          check_field("src_y", exp_piece.sy, out_if.src_y);
          check_field("piece_width", exp_piece.w, out_if.piece_width);
          check_field("piece_height", exp_piece.h, out_if.piece_height);
          check_field("last_piece", {15'd0, exp_piece.last}, {15'd0, out_if.last_piece});
          checked++;
        end
      end
      if (in_if.valid && in_if.ready) begin
        note = beat_pins.pop_front();
        if (in_if.cmd == CMD_TICK) begin
          scroll_view();
        end else if (note.pinned) begin
          want_pieces.push_back(note.pin);
          draw_count++;
          split_count[1]++;
        end else begin
          split_view(int'(in_if.dest_origin_x), int'(in_if.dest_origin_y));
        end
      end
    end
  end

  // The result side stalls at random except during the steady phase.
  always @(posedge clk) begin
    out_if.ready <= steady || ($urandom_range(99) >= 11);
  end

  function automatic void add_cfg(reg_e r, int v);
    row_t row;
    row         = '{kind: ROW_CFG, cfg_reg: REG_IMAGE_WIDTH, cmd: CMD_TICK, default: 0};
    row.kind    = ROW_CFG;
    row.cfg_reg = r;
    row.cfg_val = v;
    plan.push_back(row);
  endfunction

  function automatic void add_beat(cmd_e c, int x, int y);
    row_t row;
    row      = '{kind: ROW_BEAT, cfg_reg: REG_IMAGE_WIDTH, cmd: CMD_TICK, default: 0};
    row.kind = ROW_BEAT;
    row.cmd  = c;
    row.ox   = 13'(x);
    row.oy   = 13'(y);
    plan.push_back(row);
  endfunction

  // A draw whose single piece covers the whole image from the origin.
  function automatic void add_pinned(int x, int y, int w, int h);
    add_beat(CMD_DRAW, x, y);
    plan[$].pinned   = 1'b1;
    plan[$].pin      = make_piece(x, y, 0, 0, w, h);
    plan[$].pin.last = 1'b1;
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(4))
      0:       return $urandom_range(64, 1);
      1, 2:    return $urandom_range(1200, 200);
      default: return $urandom_range(4095, 0);
    endcase
  endfunction

  // Valid stays high between back-to-back beats; in this task it drops only for a random gap.
  task automatic send_beat(row_t row);
    beat_pins.push_back(row);
    while (!steady && $urandom_range(99) < 11) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.cmd           <= row.cmd;
    in_if.dest_origin_x <= row.ox;
    in_if.dest_origin_y <= row.oy;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
  endtask

  // Write one register, update the shadow, then read it back.
  task automatic cfg_write(reg_e r, int v);
    logic [DATA_W-1:0] mask;
    case (r)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: mask = 'hFFF;
      REG_SCROLL_SPEED:                  mask = 'h3FF;
      default:                           mask = 'h3;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    case (r)
      REG_IMAGE_WIDTH:  img_w = v & 'hFFF;
      REG_IMAGE_HEIGHT: img_h = v & 'hFFF;
      REG_SCROLL_SPEED: speed = v & 'h3FF;
      default:          heading = dir_e'(v[1:0]);
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== (DATA_W'(v) & mask)) begin
      errors++;
      $display("%0t: register %s read expected %0d got %0d", $time, r.name(),
               DATA_W'(v) & mask, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // Wait until every command has retired or the guard runs out, then let a tick finish too.
  task automatic settle();
    int guard;
    guard = 0;
    in_if.valid <= 1'b0;
    while ((want_pieces.size() != 0 || beat_pins.size() != 0) && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    row_t row;
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_if.valid         <= 1'b0;
    in_if.cmd           <= CMD_TICK;
    in_if.dest_origin_x <= '0;
    in_if.dest_origin_y <= '0;
    steady              = 1'b0;
    img_w               = WIDTH_RST;
    img_h               = HEIGHT_RST;
    speed               = 0;
    heading             = DIR_UP;
    view_l              = '0;
    view_t              = '0;
    view_r              = 14'(WIDTH_RST);
    view_b              = 14'(HEIGHT_RST);

    // After reset the view covers the image exactly, so a draw is one full-image piece,
    // also at a corner of the origin range.
    add_pinned(0, 0, WIDTH_RST, HEIGHT_RST);
    add_pinned(4095, -4096, WIDTH_RST, HEIGHT_RST);
    // Walk the view across each edge and corner so every split shape appears.
    add_cfg(REG_SCROLL_SPEED, 100);
    add_cfg(REG_SCROLL_DIR, DIR_UP);
    add_beat(CMD_TICK, 0, 0);
    add_beat(CMD_DRAW, 10, 20);
    add_cfg(REG_SCROLL_DIR, DIR_LEFT);
    add_beat(CMD_TICK, 0, 0);
    add_beat(CMD_DRAW, -5, -7);
    add_cfg(REG_SCROLL_SPEED, 200);
    add_cfg(REG_SCROLL_DIR, DIR_DOWN);
    add_beat(CMD_TICK, 0, 0);
    add_beat(CMD_DRAW, 100, -100);
    add_cfg(REG_SCROLL_SPEED, 300);
    add_cfg(REG_SCROLL_DIR, DIR_RIGHT);
    add_beat(CMD_TICK, 0, 0);
    add_beat(CMD_DRAW, 33, 44);
    add_cfg(REG_SCROLL_SPEED, 200);
    add_cfg(REG_SCROLL_DIR, DIR_LEFT);
    add_beat(CMD_TICK, 0, 0);
    add_beat(CMD_DRAW, -1, 1);
    add_cfg(REG_SCROLL_SPEED, 100);
    add_cfg(REG_SCROLL_DIR, DIR_UP);
    add_beat(CMD_TICK, 0, 0);
    add_cfg(REG_SCROLL_SPEED, 50);
    add_cfg(REG_SCROLL_DIR, DIR_LEFT);
    add_beat(CMD_TICK, 0, 0);
    add_beat(CMD_DRAW, 2000, -2000);
    add_cfg(REG_SCROLL_SPEED, 100);
    add_cfg(REG_SCROLL_DIR, DIR_RIGHT);
    add_beat(CMD_TICK, 0, 0);
    add_beat(CMD_DRAW, -3000, 3000);
    add_cfg(REG_SCROLL_SPEED, 50);
    add_cfg(REG_SCROLL_DIR, DIR_UP);
    add_beat(CMD_TICK, 0, 0);
    add_beat(CMD_DRAW, 4095, 4095);
    // Full speed in every direction forces a wrap each time.
    add_cfg(REG_SCROLL_SPEED, 1023);
    add_beat(CMD_TICK, 0, 0);
    add_cfg(REG_SCROLL_DIR, DIR_RIGHT);
    add_beat(CMD_TICK, 0, 0);
    add_cfg(REG_SCROLL_DIR, DIR_DOWN);
    add_beat(CMD_TICK, 0, 0);
    add_cfg(REG_SCROLL_DIR, DIR_LEFT);
    add_beat(CMD_TICK, 0, 0);
    // An empty image still splits with the same arithmetic.
    add_cfg(REG_IMAGE_WIDTH, 0);
    add_cfg(REG_IMAGE_HEIGHT, 0);
    add_beat(CMD_DRAW, -4096, -4096);
    add_beat(CMD_TICK, 0, 0);
    add_beat(CMD_DRAW, 7, 9);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        cfg_write(plan[i].cfg_reg, plan[i].cfg_val);
      end else begin
        send_beat(plan[i]);
      end
    end

    // Random phases, each under a fresh register setting; the fourth runs without stalls.
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin
          cfg_write(REG_IMAGE_WIDTH, 4095);
          cfg_write(REG_IMAGE_HEIGHT, 4095);
          cfg_write(REG_SCROLL_SPEED, 1023);
        end
        1: begin
          cfg_write(REG_IMAGE_WIDTH, 1);
          cfg_write(REG_IMAGE_HEIGHT, 1);
          cfg_write(REG_SCROLL_SPEED, $urandom_range(1023, 0));
        end
        2: begin
          cfg_write(REG_IMAGE_WIDTH, pick_dim());
          cfg_write(REG_IMAGE_HEIGHT, 0);
          cfg_write(REG_SCROLL_SPEED, 1023);
        end
        5: begin
          cfg_write(REG_IMAGE_WIDTH, pick_dim());
          cfg_write(REG_IMAGE_HEIGHT, pick_dim());
          cfg_write(REG_SCROLL_SPEED, 0);
        end
        default: begin
          cfg_write(REG_IMAGE_WIDTH, pick_dim());
          cfg_write(REG_IMAGE_HEIGHT, pick_dim());
          cfg_write(REG_SCROLL_SPEED, $urandom_range(400, 0));
        end
      endcase
      cfg_write(REG_SCROLL_DIR, (p < 4) ? p : $urandom_range(3, 0));
      steady = (p == 3);
      for (int i = 0; i < 43; i++) begin
        row      = '{kind: ROW_BEAT, cfg_reg: REG_IMAGE_WIDTH, cmd: CMD_TICK, default: 0};
        row.kind = ROW_BEAT;
        row.cmd  = ($urandom_range(99) < 40) ? CMD_TICK : CMD_DRAW;
        row.ox   = 13'($urandom);
        row.oy   = 13'($urandom);
        send_beat(row);
      end
      steady = 1'b0;
    end

    settle();
    if (want_pieces.size() != 0 || beat_pins.size() != 0) begin
      errors++;
      $display("%0t: %0d pieces never arrived", $time, want_pieces.size());
    end

    $display("Ran %0d ticks (%0d wrapped) and %0d draws cut into 1/2/4 pieces %0d/%0d/%0d times.",
             tick_count, wrap_count, draw_count, split_count[1], split_count[2],
             split_count[4]);
    $display("Checked %0d pieces across %0d register writes, %0d mismatches.", checked,
             settings, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
